### hw/rtl/stw_pkg.sv
// stw_pkg: shared constants, types and elaboration-time tables of the TIFF stream writer.
// Holds the sRGB threshold ROM builder and the header word generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stw_pkg;

    localparam int DIM_BITS       = 14;
    localparam int SAMPLE_BITS    = 16;
    localparam int FRAC_BITS      = SAMPLE_BITS - 2;
    localparam int COUNT_BITS     = 30;
    localparam int BYTE_STEPS     = 8;
    localparam int HDR_WORDS      = 32;
    localparam int HDR_IDX_BITS   = $clog2(HDR_WORDS);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CFG_INDEX_BITS = 2;
    localparam int BIG_BITS       = 320;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [31:0] SAMPLE_TOP = 32'(1) << (SAMPLE_BITS - 1);

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    // tiff header fields
    localparam logic [15:0] BYTE_ORDER_LE         = 16'h4949;
    localparam logic [15:0] TIFF_MAGIC            = 16'd42;
    localparam logic [31:0] IFD_OFFSET            = 32'd8;
    localparam logic [15:0] IFD_ENTRIES           = 16'd9;
    localparam logic [15:0] TAG_IMAGE_WIDTH       = 16'd256;
    localparam logic [15:0] TAG_IMAGE_LENGTH      = 16'd257;
    localparam logic [15:0] TAG_BITS_PER_SAMPLE   = 16'd258;
    localparam logic [15:0] TAG_COMPRESSION       = 16'd259;
    localparam logic [15:0] TAG_PHOTOMETRIC       = 16'd262;
    localparam logic [15:0] TAG_STRIP_OFFSETS     = 16'd273;
    localparam logic [15:0] TAG_SAMPLES_PER_PIXEL = 16'd277;
    localparam logic [15:0] TAG_ROWS_PER_STRIP    = 16'd278;
    localparam logic [15:0] TAG_STRIP_BYTE_COUNTS = 16'd279;
    localparam logic [15:0] TYPE_SHORT            = 16'd3;
    localparam logic [15:0] TYPE_LONG             = 16'd4;
    localparam logic [15:0] COUNT_ONE             = 16'd1;
    localparam logic [31:0] BPS_OFFSET            = 32'd122;
    localparam logic [31:0] STRIP_OFFSET          = 32'd128;
    localparam logic [15:0] COMPRESSION_NONE      = 16'd1;
    localparam logic [15:0] PHOTOMETRIC_RGB       = 16'd2;
    localparam logic [15:0] SAMPLES_PER_PIXEL     = 16'd3;
    localparam logic [15:0] BITS_PER_SAMPLE       = 16'd8;

    typedef logic [SAMPLE_BITS-1:0] t_thresh;
    typedef t_thresh [255:0] t_thresh_table;

    typedef struct packed {
        logic [7:0] pix;
        logic       first;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [DIM_BITS-1:0]   width;
        logic [DIM_BITS-1:0]   height;
        logic [COUNT_BITS-1:0] total;
    } t_hdr_cfg;

    function automatic logic [BIG_BITS-1:0] big_pow(input logic [31:0] base, input int n);
        logic [BIG_BITS-1:0] r;
        r = BIG_BITS'(1);
        for (int i = 0; i < n; i++) begin
            r = r * BIG_BITS'(base);
        end
        return r;
    endfunction

    localparam logic [BIG_BITS-1:0] LHS_SCALE = big_pow(32'd10761, 12);

    // true when the rounded curve value at q reaches byte k
    function automatic logic srgb_ge(input logic [31:0] q, input logic [31:0] k,
                                     input logic [BIG_BITS-1:0] k_rhs);
        logic [63:0] one;
        logic [BIG_BITS-1:0] lhs;
        one = 64'd1 << FRAC_BITS;
        if (64'(q) * 64'd10000000 <= 64'd31308 * one) begin
            return (64'd2 * 64'd1292 * 64'd255 * 64'(q) + 64'd100 * one) >=
                   (64'(k) * 64'd200 * one);
        end
        lhs = big_pow(q, 5) * LHS_SCALE;
        return lhs >= k_rhs;
    endfunction

    // smallest positive sample code that maps to at least byte k
    function automatic t_thresh_table build_srgb_thresh();
        t_thresh_table tab;
        logic [BIG_BITS-1:0] rhs;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        tab = '0;
        for (int k = 0; k < 256; k++) begin
            rhs = big_pow(32'(40 * k + 541), 12) << (5 * FRAC_BITS);
            lo = 32'd1;
            hi = SAMPLE_TOP;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (srgb_ge(mid, 32'(k), rhs)) begin
                    hi = mid;
                end else begin
                    lo = mid + 32'd1;
                end
            end
            tab[k] = SAMPLE_BITS'(lo);
        end
        return tab;
    endfunction

    localparam t_thresh_table SRGB_THRESH = build_srgb_thresh();

    function automatic logic [31:0] hdr_word(input logic [HDR_IDX_BITS-1:0] idx,
                                             input t_hdr_cfg cfg);
        logic [15:0] w16;
        logic [15:0] h16;
        logic [31:0] t32;
        logic [31:0] w;
        w16 = 16'(cfg.width);
        h16 = 16'(cfg.height);
        t32 = 32'(cfg.total);
        case (idx)
            5'd0:    w = {TIFF_MAGIC, BYTE_ORDER_LE};
            5'd1:    w = IFD_OFFSET;
            5'd2:    w = {TAG_IMAGE_WIDTH, IFD_ENTRIES};
            5'd3:    w = {COUNT_ONE, TYPE_LONG};
            5'd4:    w = {w16, 16'd0};
            5'd5:    w = {TAG_IMAGE_LENGTH, 16'd0};
            5'd6:    w = {COUNT_ONE, TYPE_LONG};
            5'd7:    w = {h16, 16'd0};
            5'd8:    w = {TAG_BITS_PER_SAMPLE, 16'd0};
            5'd9:    w = {SAMPLES_PER_PIXEL, TYPE_SHORT};
            5'd10:   w = {BPS_OFFSET[15:0], 16'd0};
            5'd11:   w = {TAG_COMPRESSION, BPS_OFFSET[31:16]};
            5'd12:   w = {COUNT_ONE, TYPE_SHORT};
            5'd13:   w = {COMPRESSION_NONE, 16'd0};
            5'd14:   w = {TAG_PHOTOMETRIC, 16'd0};
            5'd15:   w = {COUNT_ONE, TYPE_SHORT};
            5'd16:   w = {PHOTOMETRIC_RGB, 16'd0};
            5'd17:   w = {TAG_STRIP_OFFSETS, 16'd0};
            5'd18:   w = {COUNT_ONE, TYPE_LONG};
            5'd19:   w = {STRIP_OFFSET[15:0], 16'd0};
            5'd20:   w = {TAG_SAMPLES_PER_PIXEL, STRIP_OFFSET[31:16]};
            5'd21:   w = {COUNT_ONE, TYPE_SHORT};
            5'd22:   w = {SAMPLES_PER_PIXEL, 16'd0};
            5'd23:   w = {TAG_ROWS_PER_STRIP, 16'd0};
            5'd24:   w = {COUNT_ONE, TYPE_LONG};
            5'd25:   w = {h16, 16'd0};
            5'd26:   w = {TAG_STRIP_BYTE_COUNTS, 16'd0};
            5'd27:   w = {COUNT_ONE, TYPE_LONG};
            5'd28:   w = {t32[15:0], 16'd0};
            5'd29:   w = {16'd0, t32[31:16]};
            5'd30:   w = {BITS_PER_SAMPLE, 16'd0};
            5'd31:   w = {BITS_PER_SAMPLE, BITS_PER_SAMPLE};
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/stw_sample_if.sv
// stw_sample_if: valid/ready channel carrying one linear sample per beat.
// Depends on stw_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

interface stw_sample_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [stw_pkg::SAMPLE_BITS-1:0] linear_sample;

    modport source (output valid, output linear_sample, input ready);
    modport sink   (input valid, input linear_sample, output ready);
endinterface

`default_nettype wire

### hw/rtl/stw_word_if.sv
// stw_word_if: valid/ready channel carrying one 32-bit file word per beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface stw_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] file_word;
    logic [2:0]  valid_bytes;
    logic        last_word;

    modport source (output valid, output file_word, output valid_bytes, output last_word,
                    input ready);
    modport sink   (input valid, input file_word, input valid_bytes, input last_word,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/stw_front.sv
// stw_front: config registers, frame counter and the 8-stage sRGB threshold search.
// Depends on stw_pkg and stw_sample_if.
`timescale 1ns / 1ps
`default_nettype none

module stw_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    stw_sample_if.sink                                 i_sample,
    input  wire logic                                  i_cfg_we,
    input  wire logic [stw_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire logic [stw_pkg::DIM_BITS-1:0]          i_cfg_data,
    output stw_pkg::t_item                             o_item,
    output logic                                       o_item_valid,
    input  wire logic                                  i_item_ready,
    output stw_pkg::t_hdr_cfg                          o_hdr_cfg
);

    localparam int NS = stw_pkg::BYTE_STEPS;
    localparam logic [1:0] CFG_SETTLE = 2'd2;

    logic [stw_pkg::DIM_BITS-1:0]     r_width;
    logic [stw_pkg::DIM_BITS-1:0]     r_height;
    logic [2*stw_pkg::DIM_BITS-1:0]   r_area;
    logic [stw_pkg::COUNT_BITS-1:0]   r_total;
    logic [stw_pkg::COUNT_BITS-1:0]   n_total;
    logic [1:0]                       r_busy;
    logic [stw_pkg::COUNT_BITS-1:0]   r_count;
    logic [stw_pkg::DIM_BITS-1:0]     cfg_val;
    logic [63:0]                      area3;
    logic [stw_pkg::COUNT_BITS:0]     cnt_next;
    logic                             frame_last;
    logic                             advance;
    logic                             accept;
    stw_pkg::t_thresh                 q_eff;

    logic [NS:0]      r_vld;
    stw_pkg::t_thresh r_q     [NS];
    logic [7:0]       r_k     [NS+1];
    logic             r_first [NS+1];
    logic             r_last  [NS+1];

    // ---- configuration and strip size ----
    assign cfg_val = (i_cfg_data == '0) ? stw_pkg::DIM_BITS'(1) : i_cfg_data;
    assign area3   = 64'(r_area) + (64'(r_area) << 1);
    assign n_total = (area3 > 64'(stw_pkg::COUNT_MAX)) ? stw_pkg::COUNT_MAX
                                                       : area3[stw_pkg::COUNT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= stw_pkg::DIM_BITS'(1);
            r_height <= stw_pkg::DIM_BITS'(1);
            r_area   <= (2*stw_pkg::DIM_BITS)'(1);
            r_total  <= stw_pkg::COUNT_BITS'(3);
            r_busy   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    stw_pkg::CFG_IMAGE_WIDTH:  r_width  <= cfg_val;
                    stw_pkg::CFG_IMAGE_HEIGHT: r_height <= cfg_val;
                    default: ;
                endcase
            end
            // product is registered in r_area, then the strip size in r_total
            r_area  <= (2*stw_pkg::DIM_BITS)'(r_width) * (2*stw_pkg::DIM_BITS)'(r_height);
            r_total <= n_total;
            if (i_cfg_we) begin
                r_busy <= CFG_SETTLE;
            end else if (r_busy != '0) begin
                r_busy <= r_busy - 2'd1;
            end
        end
    end

    assign o_hdr_cfg = '{width: r_width, height: r_height, total: r_total};

    // ---- intake and frame position ----
    assign advance        = !r_vld[NS] || i_item_ready;
    assign i_sample.ready = advance && (r_busy == '0);
    assign accept         = i_sample.valid && i_sample.ready;
    assign cnt_next       = {1'b0, r_count} + (stw_pkg::COUNT_BITS+1)'(1);
    assign frame_last     = cnt_next >= {1'b0, r_total};
    assign q_eff          = i_sample.linear_sample[stw_pkg::SAMPLE_BITS-1]
                            ? '0 : stw_pkg::t_thresh'(i_sample.linear_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= frame_last ? '0 : cnt_next[stw_pkg::COUNT_BITS-1:0];
        end
    end

    // ---- threshold search, one result bit per stage ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[NS-1:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_q[0]     <= q_eff;
            r_k[0]     <= '0;
            r_first[0] <= (r_count == '0);
            r_last[0]  <= frame_last;
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_step
        localparam logic [7:0] STEP_BIT = 8'(1 << (NS - 1 - s));
        logic [7:0] cand;
        logic       take;

        assign cand = r_k[s] | STEP_BIT;
        assign take = r_q[s] >= stw_pkg::SRGB_THRESH[cand];

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_k[s+1]     <= take ? cand : r_k[s];
                r_first[s+1] <= r_first[s];
                r_last[s+1]  <= r_last[s];
            end
        end

        if (s + 1 < NS) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (advance) begin
                    r_q[s+1] <= r_q[s];
                end
            end
        end
    end

    assign o_item_valid = r_vld[NS];
    assign o_item       = '{pix: r_k[NS], first: r_first[NS], last: r_last[NS]};

endmodule

`default_nettype wire

### hw/rtl/stw_queue.sv
// stw_queue: small register queue of converted bytes between front and back.
// Depends on stw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stw_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push_valid,
    input  wire stw_pkg::t_item  i_push_item,
    output logic                 o_push_ready,
    output logic                 o_pop_valid,
    output stw_pkg::t_item       o_pop_item,
    input  wire logic            i_pop
);

    localparam int PB = stw_pkg::QUEUE_PTR_BITS;

    stw_pkg::t_item r_mem [stw_pkg::QUEUE_DEPTH];
    logic [PB-1:0]  r_wptr;
    logic [PB-1:0]  r_rptr;
    logic [PB:0]    r_cnt;
    logic           push;
    logic           pop;

    assign o_push_ready = r_cnt != (PB+1)'(stw_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_item   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PB'(stw_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wptr + PB'(1);
            end
            if (pop) begin
                r_rptr <= (r_rptr == PB'(stw_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rptr + PB'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + (PB+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PB+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/stw_back.sv
// stw_back: header burst and byte packing into little-endian file words.
// Depends on stw_pkg and stw_word_if.
`timescale 1ns / 1ps
`default_nettype none

module stw_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_head_valid,
    input  wire stw_pkg::t_item    i_head,
    output logic                   o_pop,
    input  wire stw_pkg::t_hdr_cfg i_hdr_cfg,
    stw_word_if.source             o_word
);

    localparam int HB = stw_pkg::HDR_IDX_BITS;
    localparam logic [2:0] VB_FULL = 3'd4;

    logic [23:0]   r_pack;
    logic [1:0]    r_fill;
    logic [HB-1:0] r_hdr_idx;
    logic          r_hdr_done;
    logic          r_ovalid;
    logic [31:0]   r_word;
    logic [2:0]    r_vb;
    logic          r_last;
    logic [31:0]   merged;
    logic          emit;
    logic          hdr_mode;
    logic          out_free;
    logic          do_hdr;
    logic          do_pack;

    assign merged   = {8'd0, r_pack} | ({24'd0, i_head.pix} << {r_fill, 3'b000});
    assign emit     = i_head.last || (r_fill == 2'd3);
    assign hdr_mode = i_head_valid && i_head.first && !r_hdr_done;
    assign out_free = !r_ovalid || o_word.ready;
    assign do_hdr   = hdr_mode && out_free;
    // a byte that completes no word is absorbed even while the output stalls
    assign do_pack  = i_head_valid && !hdr_mode && (!emit || out_free);
    assign o_pop    = do_pack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack     <= '0;
            r_fill     <= '0;
            r_hdr_idx  <= '0;
            r_hdr_done <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (do_hdr) begin
                r_hdr_idx <= (r_hdr_idx == HB'(stw_pkg::HDR_WORDS - 1)) ? '0
                                                                        : r_hdr_idx + HB'(1);
                if (r_hdr_idx == HB'(stw_pkg::HDR_WORDS - 1)) begin
                    r_hdr_done <= 1'b1;
                end
            end
            if (do_pack) begin
                r_hdr_done <= 1'b0;
                if (emit) begin
                    r_pack <= '0;
                    r_fill <= '0;
                end else begin
                    r_pack <= merged[23:0];
                    r_fill <= r_fill + 2'd1;
                end
            end
            if (do_hdr || (do_pack && emit)) begin
                r_ovalid <= 1'b1;
            end else if (o_word.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_hdr) begin
            r_word <= stw_pkg::hdr_word(r_hdr_idx, i_hdr_cfg);
            r_vb   <= VB_FULL;
            r_last <= 1'b0;
        end else if (do_pack && emit) begin
            r_word <= merged;
            r_vb   <= {1'b0, r_fill} + 3'd1;
            r_last <= i_head.last;
        end
    end

    assign o_word.valid       = r_ovalid;
    assign o_word.file_word   = r_word;
    assign o_word.valid_bytes = r_vb;
    assign o_word.last_word   = r_last;

endmodule

`default_nettype wire

### hw/rtl/srgb_baseline_tiff_stream_writer.sv
// srgb_baseline_tiff_stream_writer: top level, linear samples in, baseline TIFF words out.
// Depends on stw_pkg, stw_sample_if, stw_word_if, stw_front, stw_queue, stw_back.
//
//   channel    direction  beat carries
//   i_sample   in         linear_sample, signed Q1.14, R,G,B order
//   o_word     out        file_word, valid_bytes, last_word
//   i_cfg_*    in         index 0 image_width, index 1 image_height
//
// One sample per cycle while the back end keeps up and no register write settles; a sample
// passes the input register, eight threshold-search stages and the queue to the back end.
// The back end sends the 32 header words before the first sample of a frame; the input keeps
// flowing until the four-entry queue and the search pipeline are full.
// Input ready drops after each register write while the strip size settles.
// Synchronous active-low reset; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module srgb_baseline_tiff_stream_writer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    stw_sample_if.sink                               i_sample,
    stw_word_if.source                               o_word,
    input  wire logic                                i_cfg_we,
    input  wire logic [stw_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [stw_pkg::DIM_BITS-1:0]        i_cfg_data
);

    stw_pkg::t_item    front_item;
    logic              front_valid;
    logic              queue_ready;
    stw_pkg::t_item    head_item;
    logic              head_valid;
    logic              head_pop;
    stw_pkg::t_hdr_cfg hdr_cfg;

    stw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (i_sample),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_item       (front_item),
        .o_item_valid (front_valid),
        .i_item_ready (queue_ready),
        .o_hdr_cfg    (hdr_cfg)
    );

    stw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_item  (front_item),
        .o_push_ready (queue_ready),
        .o_pop_valid  (head_valid),
        .o_pop_item   (head_item),
        .i_pop        (head_pop)
    );

    stw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_item),
        .o_pop        (head_pop),
        .i_hdr_cfg    (hdr_cfg),
        .o_word       (o_word)
    );

endmodule

`default_nettype wire

### hw/rtl/stw_checker.sv
// stw_checker: assertions on the output channel of the TIFF stream writer, bound to the top.
// Depends on stw_pkg and srgb_baseline_tiff_stream_writer.
`timescale 1ns / 1ps
`default_nettype none

module stw_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic [31:0] i_file_word,
    input wire logic [2:0]  i_valid_bytes,
    input wire logic        i_last_word
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_file_word) &&
                                $stable(i_valid_bytes) && $stable(i_last_word))
        else $error("stalled output beat changed");

    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last_word |-> i_valid_bytes == 3'd4)
        else $error("partial word before end of file");

    // bytes above the valid count are zero in the closing word
    a_tail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last_word |->
            (i_valid_bytes == 3'd1 && i_file_word[31:8] == 24'd0) ||
            (i_valid_bytes == 3'd2 && i_file_word[31:16] == 16'd0) ||
            (i_valid_bytes == 3'd3 && i_file_word[31:24] == 8'd0) ||
            (i_valid_bytes == 3'd4))
        else $error("bad closing word");

    // a new file that follows a closing word without a gap opens with the byte order mark and magic number
    a_new_file: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && i_last_word |=>
            !i_valid || i_file_word == {stw_pkg::TIFF_MAGIC, stw_pkg::BYTE_ORDER_LE})
        else $error("file does not start with a header");

endmodule

bind srgb_baseline_tiff_stream_writer stw_checker u_stw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_word.valid),
    .i_ready       (o_word.ready),
    .i_file_word   (o_word.file_word),
    .i_valid_bytes (o_word.valid_bytes),
    .i_last_word   (o_word.last_word)
);

`default_nettype wire
